// File: src/wspc_pkg.sv
// Package for the wheel speed PI controller.
// Holds shared types, constants and the clamp helper; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wspc_pkg;

    localparam int EDGE_W  = 10;
    localparam int SPEED_W = 16;
    localparam int GAIN_W  = 16;
    localparam int DUTY_W  = 16;
    localparam int LEN_W   = 7;
    localparam int SUM_W   = 22;
    localparam int DIV_W   = SUM_W + 1;
    localparam int ERR_W   = SPEED_W + 1;
    localparam int PROD_W  = 2 * ERR_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int WCNT_W  = 7;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 16;
    localparam int FILL_CAP = 126;

    localparam logic [DUTY_W-1:0] WARMUP_DUTY = 16'd6554;

    localparam logic [CFG_AW-1:0] REG_SPEED_SCALE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_AVG_LENGTH  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_PROP_GAIN   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_INTEG_GAIN  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_DUTY_MAX    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_DUTY_MIN    = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_CHECK,
        ST_BRANCH,
        ST_MEAN,
        ST_RUN_V,
        ST_RUN_A,
        ST_ERR,
        ST_IMUL,
        ST_IACC,
        ST_PMUL,
        ST_DUTY,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_SPEED,
        MUL_INTEG,
        MUL_PROP
    } t_mul_sel;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_V,
        DIV_AVG
    } t_div_sel;

    typedef enum logic [1:0] {
        BR_FILL,
        BR_MEAN,
        BR_RUN
    } t_branch;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     v_en;
        logic     fill_upd;
        logic     div_start;
        t_div_sel div_sel;
        logic     mean_upd;
        logic     qv_en;
        logic     run_upd;
        logic     err_en;
        logic     integ_en;
        logic     duty_en;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic    prod_zero;
        t_branch branch;
        logic    div_busy;
        logic    out_free;
    } t_stat;

    function automatic logic [DUTY_W-1:0] clamp_duty(
        input logic signed [ACC_W-1:0] x,
        input logic [DUTY_W-1:0]       hi,
        input logic [DUTY_W-1:0]       lo
    );
        logic signed [ACC_W-1:0] hi_s;
        logic signed [ACC_W-1:0] lo_s;
        logic [DUTY_W-1:0]       res;
        hi_s = $signed({{(ACC_W-DUTY_W){1'b0}}, hi});
        lo_s = $signed({{(ACC_W-DUTY_W){1'b0}}, lo});
        if (x > hi_s) begin
            res = hi;
        end else if (x < lo_s) begin
            res = lo;
        end else begin
            res = x[DUTY_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: src/wspc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wspc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module wspc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [wspc_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [wspc_pkg::LEN_W-1:0]  i_divisor,
    output logic                             o_busy,
    output logic [wspc_pkg::DIV_W-1:0]       o_quotient
);

    localparam int DW    = wspc_pkg::DIV_W;
    localparam int LW    = wspc_pkg::LEN_W;
    localparam int CNT_W = $clog2(DW);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_quo;
    logic [LW-1:0]    r_rem;
    logic [LW-1:0]    r_div;

    logic [LW:0]      trial;
    logic [LW:0]      diff;
    logic             ge;
    logic [LW-1:0]    n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[LW-1:0] : trial[LW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DW - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: src/wspc_datapath.sv
// Datapath: config registers, shared multiplier, divider, averaging and PI state.
// Depends on wspc_pkg and wspc_div; driven by commands from wspc_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module wspc_datapath #(
    parameter int MAX_AVG_LENGTH = 64,
    parameter int WARMUP_TICKS   = 100
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [wspc_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [wspc_pkg::CFG_DW-1:0]  i_cfg_wdata,
    input  wire logic [wspc_pkg::EDGE_W-1:0]  i_edge_count,
    input  wire logic [wspc_pkg::SPEED_W-1:0] i_target_speed,
    input  wire wspc_pkg::t_cmd               i_cmd,
    output wspc_pkg::t_stat                   o_stat,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [wspc_pkg::DUTY_W-1:0]       o_duty,
    output logic [wspc_pkg::SPEED_W-1:0]      o_avg_speed,
    output logic                              o_warming_up
);

    localparam int SW  = wspc_pkg::SPEED_W;
    localparam int DTW = wspc_pkg::DUTY_W;
    localparam int LW  = wspc_pkg::LEN_W;
    localparam int PW  = wspc_pkg::PROD_W;
    localparam int AW  = wspc_pkg::ACC_W;
    localparam int EW  = wspc_pkg::ERR_W;
    localparam int CAP_RAW = (MAX_AVG_LENGTH < wspc_pkg::FILL_CAP) ?
                             MAX_AVG_LENGTH : wspc_pkg::FILL_CAP;
    localparam int WIN_CAP = (CAP_RAW < 1) ? 1 : CAP_RAW;

    logic [SW-1:0]  r_scale;
    logic [LW-1:0]  r_len;
    logic [15:0]    r_pgain;
    logic [15:0]    r_igain;
    logic [DTW-1:0] r_dmax;
    logic [DTW-1:0] r_dmin;

    logic [wspc_pkg::EDGE_W-1:0] r_edges;
    logic [SW-1:0]               r_target;
    logic signed [PW-1:0]        r_prod;
    logic [SW-1:0]               r_v;
    logic [wspc_pkg::SUM_W-1:0]  r_sum;
    logic [SW-1:0]               r_avg;
    logic [LW-1:0]               r_fill;
    logic [SW-1:0]               r_qv;
    logic signed [EW-1:0]        r_err;
    logic [DTW-1:0]              r_integ;
    logic [wspc_pkg::WCNT_W-1:0] r_wcnt;
    logic [DTW-1:0]              r_duty;
    logic                        r_warm;
    logic                        r_o_valid;
    logic [DTW-1:0]              r_o_duty;
    logic [SW-1:0]               r_o_avg;
    logic                        r_o_warm;

    logic [LW-1:0]               win;
    logic signed [EW-1:0]        mul_a;
    logic signed [EW-1:0]        mul_b;
    logic [SW-1:0]               v_sat;
    logic [wspc_pkg::DIV_W-1:0]  sum_v;
    logic [wspc_pkg::DIV_W-1:0]  div_dividend;
    logic                        div_busy;
    logic [wspc_pkg::DIV_W-1:0]  div_quo;
    logic [SW:0]                 run_avg;
    logic signed [AW-1:0]        acc_sum;
    logic                        warm_now;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 16'd256;
            r_len   <= 7'd8;
            r_pgain <= 16'd256;
            r_igain <= 16'd26;
            r_dmax  <= 16'hFFFF;
            r_dmin  <= 16'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                wspc_pkg::REG_SPEED_SCALE: r_scale <= i_cfg_wdata;
                wspc_pkg::REG_AVG_LENGTH:  r_len   <= i_cfg_wdata[LW-1:0];
                wspc_pkg::REG_PROP_GAIN:   r_pgain <= i_cfg_wdata;
                wspc_pkg::REG_INTEG_GAIN:  r_igain <= i_cfg_wdata;
                wspc_pkg::REG_DUTY_MAX:    r_dmax  <= i_cfg_wdata;
                wspc_pkg::REG_DUTY_MIN:    r_dmin  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_len == '0) begin
            win = LW'(1);
        end else if (r_len > LW'(WIN_CAP)) begin
            win = LW'(WIN_CAP);
        end else begin
            win = r_len;
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            wspc_pkg::MUL_SPEED: begin
                mul_a = $signed({{(EW-wspc_pkg::EDGE_W){1'b0}}, r_edges});
                mul_b = $signed({1'b0, r_scale});
            end
            wspc_pkg::MUL_INTEG: begin
                mul_a = $signed({1'b0, r_igain});
                mul_b = r_err;
            end
            wspc_pkg::MUL_PROP: begin
                mul_a = $signed({1'b0, r_pgain});
                mul_b = r_err;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign v_sat = (|r_prod[PW-1:SW]) ? {SW{1'b1}} : r_prod[SW-1:0];
    assign sum_v = {1'b0, r_sum} + {{(wspc_pkg::DIV_W-SW){1'b0}}, r_v};

    always_comb begin
        case (i_cmd.div_sel)
            wspc_pkg::DIV_MEAN: div_dividend = sum_v;
            wspc_pkg::DIV_V:    div_dividend = {{(wspc_pkg::DIV_W-SW){1'b0}}, r_v};
            wspc_pkg::DIV_AVG:  div_dividend = {{(wspc_pkg::DIV_W-SW){1'b0}}, r_avg};
            default:            div_dividend = '0;
        endcase
    end

    wspc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (win),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    assign run_avg  = {1'b0, r_avg} + {1'b0, r_qv} - {1'b0, div_quo[SW-1:0]};
    assign acc_sum  = $signed({r_prod[PW-1], r_prod}) +
                      $signed({{(AW-DTW){1'b0}}, r_integ});
    assign warm_now = (r_wcnt < wspc_pkg::WCNT_W'(WARMUP_TICKS));

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_edges  <= i_edge_count;
            r_target <= i_target_speed;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.v_en) begin
            r_v <= v_sat;
        end
        if (i_cmd.qv_en) begin
            r_qv <= div_quo[SW-1:0];
        end
        if (i_cmd.err_en) begin
            r_err <= $signed({1'b0, r_target}) - $signed({1'b0, r_avg});
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_avg   <= '0;
            r_fill  <= '0;
            r_integ <= '0;
            r_wcnt  <= '0;
        end else begin
            if (i_cmd.fill_upd) begin
                r_sum  <= sum_v[wspc_pkg::SUM_W] ? {wspc_pkg::SUM_W{1'b1}} :
                          sum_v[wspc_pkg::SUM_W-1:0];
                r_avg  <= r_v;
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.mean_upd) begin
                r_avg  <= (|div_quo[wspc_pkg::DIV_W-1:SW]) ? {SW{1'b1}} :
                          div_quo[SW-1:0];
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.run_upd) begin
                r_avg <= run_avg[SW] ? {SW{1'b1}} : run_avg[SW-1:0];
            end
            if (i_cmd.integ_en) begin
                r_integ <= wspc_pkg::clamp_duty(acc_sum, r_dmax, r_dmin);
            end
            if (i_cmd.duty_en && warm_now) begin
                r_wcnt  <= r_wcnt + 1'b1;
                r_integ <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.duty_en) begin
            r_duty <= warm_now ? wspc_pkg::WARMUP_DUTY :
                      wspc_pkg::clamp_duty(acc_sum, r_dmax, r_dmin);
            r_warm <= warm_now;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_duty <= r_duty;
            r_o_avg  <= r_avg;
            r_o_warm <= r_warm;
        end
    end

    always_comb begin
        o_stat.prod_zero = (r_prod == '0);
        if (r_fill < win) begin
            o_stat.branch = wspc_pkg::BR_FILL;
        end else if (r_fill == win) begin
            o_stat.branch = wspc_pkg::BR_MEAN;
        end else begin
            o_stat.branch = wspc_pkg::BR_RUN;
        end
        o_stat.div_busy = div_busy;
        o_stat.out_free = !r_o_valid || i_out_ready;
    end

    assign o_out_valid  = r_o_valid;
    assign o_duty       = r_o_duty;
    assign o_avg_speed  = r_o_avg;
    assign o_warming_up = r_o_warm;

endmodule

`default_nettype wire

// File: src/wspc_ctrl.sv
// Controller state machine that sequences one tick through the datapath.
// Depends on wspc_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module wspc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire wspc_pkg::t_stat i_stat,
    output wspc_pkg::t_cmd       o_cmd
);

    wspc_pkg::t_state r_state;
    wspc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wspc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wspc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = wspc_pkg::ST_SCALE;
                end
            end
            wspc_pkg::ST_SCALE: n_state = wspc_pkg::ST_CHECK;
            wspc_pkg::ST_CHECK: begin
                n_state = i_stat.prod_zero ? wspc_pkg::ST_IDLE : wspc_pkg::ST_BRANCH;
            end
            wspc_pkg::ST_BRANCH: begin
                case (i_stat.branch)
                    wspc_pkg::BR_FILL: n_state = wspc_pkg::ST_ERR;
                    wspc_pkg::BR_MEAN: n_state = wspc_pkg::ST_MEAN;
                    default:           n_state = wspc_pkg::ST_RUN_V;
                endcase
            end
            wspc_pkg::ST_MEAN: begin
                if (!i_stat.div_busy) begin
                    n_state = wspc_pkg::ST_ERR;
                end
            end
            wspc_pkg::ST_RUN_V: begin
                if (!i_stat.div_busy) begin
                    n_state = wspc_pkg::ST_RUN_A;
                end
            end
            wspc_pkg::ST_RUN_A: begin
                if (!i_stat.div_busy) begin
                    n_state = wspc_pkg::ST_ERR;
                end
            end
            wspc_pkg::ST_ERR:  n_state = wspc_pkg::ST_IMUL;
            wspc_pkg::ST_IMUL: n_state = wspc_pkg::ST_IACC;
            wspc_pkg::ST_IACC: n_state = wspc_pkg::ST_PMUL;
            wspc_pkg::ST_PMUL: n_state = wspc_pkg::ST_DUTY;
            wspc_pkg::ST_DUTY: n_state = wspc_pkg::ST_OUT;
            wspc_pkg::ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = wspc_pkg::ST_IDLE;
                end
            end
            default: n_state = wspc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = wspc_pkg::MUL_SPEED;
        o_cmd.div_sel = wspc_pkg::DIV_MEAN;
        o_in_ready    = 1'b0;
        case (r_state)
            wspc_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            wspc_pkg::ST_SCALE: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = wspc_pkg::MUL_SPEED;
            end
            wspc_pkg::ST_CHECK: begin
                o_cmd.v_en = !i_stat.prod_zero;
            end
            wspc_pkg::ST_BRANCH: begin
                case (i_stat.branch)
                    wspc_pkg::BR_FILL: o_cmd.fill_upd = 1'b1;
                    wspc_pkg::BR_MEAN: begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = wspc_pkg::DIV_MEAN;
                    end
                    default: begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = wspc_pkg::DIV_V;
                    end
                endcase
            end
            wspc_pkg::ST_MEAN: begin
                o_cmd.mean_upd = !i_stat.div_busy;
            end
            wspc_pkg::ST_RUN_V: begin
                o_cmd.qv_en     = !i_stat.div_busy;
                o_cmd.div_start = !i_stat.div_busy;
                o_cmd.div_sel   = wspc_pkg::DIV_AVG;
            end
            wspc_pkg::ST_RUN_A: begin
                o_cmd.run_upd = !i_stat.div_busy;
            end
            wspc_pkg::ST_ERR: begin
                o_cmd.err_en = 1'b1;
            end
            wspc_pkg::ST_IMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = wspc_pkg::MUL_INTEG;
            end
            wspc_pkg::ST_IACC: begin
                o_cmd.integ_en = 1'b1;
            end
            wspc_pkg::ST_PMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = wspc_pkg::MUL_PROP;
            end
            wspc_pkg::ST_DUTY: begin
                o_cmd.duty_en = 1'b1;
            end
            wspc_pkg::ST_OUT: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: src/wheel_speed_pi_controller_top.sv
// Top level of the wheel speed PI controller: stream ports, config port.
// Depends on wspc_pkg, wspc_ctrl and wspc_datapath.
`timescale 1ns / 1ps
`default_nettype none

// One tick is taken at a time. A tick with zero scaled speed is dropped with
// no output beat. Otherwise the tick may wait for the previous output beat
// to be taken. The shared divider, which produces one quotient bit per
// cycle over 23 bits, runs once per tick at the fill point and twice per tick
// once the running average is active. The next tick is accepted while a
// finished beat waits at the output.
module wheel_speed_pi_controller_top #(
    parameter int MAX_AVG_LENGTH = 64,
    parameter int WARMUP_TICKS   = 100
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [wspc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [wspc_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [31:0]                 s_axis_tdata,  // edge_count, target_speed
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [31:0]                      m_axis_tdata,  // duty, avg_speed
    output logic                             m_axis_tuser   // warming_up
);

    wspc_pkg::t_cmd  cmd;
    wspc_pkg::t_stat stat;
    logic [wspc_pkg::DUTY_W-1:0]  duty;
    logic [wspc_pkg::SPEED_W-1:0] avg_speed;

    wspc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wspc_datapath #(
        .MAX_AVG_LENGTH (MAX_AVG_LENGTH),
        .WARMUP_TICKS   (WARMUP_TICKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_edge_count   (s_axis_tdata[9:0]),
        .i_target_speed (s_axis_tdata[25:10]),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_duty         (duty),
        .o_avg_speed    (avg_speed),
        .o_warming_up   (m_axis_tuser)
    );

    assign m_axis_tdata = {avg_speed, duty};

endmodule

`default_nettype wire

// File: src/wspc_checker.sv
// Port-level checker for the wheel speed PI controller, bound to the top level.
// Depends on wspc_pkg for the warm-up duty constant.
`timescale 1ns / 1ps
`default_nettype none

module wspc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid after reset");

    a_one_tick_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("second tick accepted while one is in work");

    a_warmup_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:0] == wspc_pkg::WARMUP_DUTY)
        else $error("warm-up beat with wrong duty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

endmodule

bind wheel_speed_pi_controller_top wspc_checker u_wspc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: verif/duty_cmd_checker.sv
// Duty command checker for the wheel speed PI controller: tracks register
// writes, predicts each duty command from the accepted ticks and compares.
// Depends on wspc_pkg.
`timescale 1ns / 1ps

module duty_cmd_checker #(
    parameter int MAX_WINDOW   = 64,
    parameter int WARMUP_TICKS = 100
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [wspc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [wspc_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  wire logic                        i_tick_valid,
    input  wire logic                        i_tick_ready,
    input  wire logic [31:0]                 i_tick_data,   // edge_count, target_speed
    input  wire logic                        i_cmd_valid,
    input  wire logic                        i_cmd_ready,
    input  wire logic [31:0]                 i_cmd_data,    // duty, avg_speed
    input  wire logic                        i_cmd_warm,    // warming_up
    output int                               o_pending,
    output int                               o_fail_count
);

    localparam int          SUM_BITS  = wspc_pkg::SUM_W;
    localparam int unsigned WIN_CAP   = (MAX_WINDOW > wspc_pkg::FILL_CAP) ?
                                        wspc_pkg::FILL_CAP :
                                        ((MAX_WINDOW < 1) ? 1 : MAX_WINDOW);
    localparam int unsigned SUM_MAX   = (1 << SUM_BITS) - 1;
    localparam int unsigned SPEED_MAX = 65535;
    localparam logic [15:0] DUTY_WARM = 16'd6554;

    typedef struct packed {
        logic [15:0] duty;
        logic [15:0] avg_speed;
        logic        warming_up;
    } t_motor_cmd;

    t_motor_cmd        expected_cmds[$];
    t_motor_cmd        oldest_cmd;
    int                fail_total = 0;

    logic [15:0]       cfg_scale;
    logic [6:0]        cfg_len;
    logic [15:0]       cfg_kp;
    logic [15:0]       cfg_ki;
    logic [15:0]       cfg_dmax;
    logic [15:0]       cfg_dmin;

    logic [6:0]          fill_cnt;
    logic [SUM_BITS-1:0] speed_sum;
    logic [15:0]         speed_avg;
    logic signed [31:0]  integ_acc;
    logic [6:0]          warm_cnt;

    function automatic longint clamp_to_range(longint x);
        longint hi;
        longint lo;
        hi = longint'(cfg_dmax);
        lo = longint'(cfg_dmin);
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    task automatic report(input string what, input longint want, input longint got);
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
        fail_total++;
    endtask

    task automatic predict_duty_cmd(input logic [9:0] edges, input logic [15:0] target);
        int unsigned prod;
        int unsigned vel;
        int unsigned win;
        int unsigned total;
        int unsigned avg_next;
        longint      err;
        longint      kp;
        longint      ki;
        t_motor_cmd  cmd;
        prod = 32'(edges) * 32'(cfg_scale);
        if (prod == 0) return;
        vel = (prod > SPEED_MAX) ? SPEED_MAX : prod;
        win = (cfg_len == 7'd0) ? 1 : 32'(cfg_len);
        if (win > WIN_CAP) win = WIN_CAP;

        if (32'(fill_cnt) < win) begin
            total     = 32'(speed_sum) + vel;
            speed_sum = SUM_BITS'((total > SUM_MAX) ? SUM_MAX : total);
            speed_avg = 16'(vel);
            fill_cnt  = fill_cnt + 7'd1;
        end else if (32'(fill_cnt) == win) begin
            total     = 32'(speed_sum) + vel;
            avg_next  = total / win;
            speed_avg = 16'((avg_next > SPEED_MAX) ? SPEED_MAX : avg_next);
            fill_cnt  = fill_cnt + 7'd1;
        end else begin
            avg_next  = 32'(speed_avg) + vel / win - 32'(speed_avg) / win;
            speed_avg = 16'((avg_next > SPEED_MAX) ? SPEED_MAX : avg_next);
        end

        err = longint'(target) - longint'(speed_avg);
        kp  = longint'(cfg_kp);
        ki  = longint'(cfg_ki);
        integ_acc = 32'(clamp_to_range(longint'(integ_acc) + ki * err));
        cmd.duty       = 16'(clamp_to_range(kp * err + longint'(integ_acc)));
        cmd.warming_up = 1'b0;
        if (32'(warm_cnt) < WARMUP_TICKS) begin
            cmd.duty       = DUTY_WARM;
            warm_cnt       = warm_cnt + 7'd1;
            integ_acc      = '0;
            cmd.warming_up = 1'b1;
        end
        cmd.avg_speed = speed_avg;
        expected_cmds.push_back(cmd);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_scale = 16'd256;
            cfg_len   = 7'd8;
            cfg_kp    = 16'd256;
            cfg_ki    = 16'd26;
            cfg_dmax  = 16'hFFFF;
            cfg_dmin  = 16'd0;
            fill_cnt  = '0;
            speed_sum = '0;
            speed_avg = '0;
            integ_acc = '0;
            warm_cnt  = '0;
            expected_cmds.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    wspc_pkg::REG_SPEED_SCALE: cfg_scale = i_cfg_wdata;
                    wspc_pkg::REG_AVG_LENGTH:  cfg_len   = i_cfg_wdata[6:0];
                    wspc_pkg::REG_PROP_GAIN:   cfg_kp    = i_cfg_wdata;
                    wspc_pkg::REG_INTEG_GAIN:  cfg_ki    = i_cfg_wdata;
                    wspc_pkg::REG_DUTY_MAX:    cfg_dmax  = i_cfg_wdata;
                    wspc_pkg::REG_DUTY_MIN:    cfg_dmin  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd_valid && i_cmd_ready) begin
                if (expected_cmds.size() == 0) begin
                    $display("%0t: result beat mismatch, expected none actual duty %0d avg %0d",
                             $time, i_cmd_data[15:0], i_cmd_data[31:16]);
                    fail_total++;
                end else begin
                    oldest_cmd = expected_cmds.pop_front();
                    if (oldest_cmd.duty != i_cmd_data[15:0])
                        report("duty", oldest_cmd.duty, i_cmd_data[15:0]);
                    if (oldest_cmd.avg_speed != i_cmd_data[31:16])
                        report("avg_speed", oldest_cmd.avg_speed, i_cmd_data[31:16]);
                    if (oldest_cmd.warming_up != i_cmd_warm)
                        report("warming_up", oldest_cmd.warming_up, i_cmd_warm);
                end
            end
            if (i_tick_valid && i_tick_ready) begin
                predict_duty_cmd(i_tick_data[9:0], i_tick_data[25:10]);
            end
        end
        o_pending    <= expected_cmds.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: verif/testbench.sv
// Testbench top for the wheel speed PI controller: drives ticks, register
// writes and output back-pressure, and prints the verdict.
// Depends on wspc_pkg, wheel_speed_pi_controller_top and duty_cmd_checker.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [15:0] scale;
        logic [15:0] len;
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] dmax;
        logic [15:0] dmin;
    } t_loop_cfg;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_wr_en;
    logic [wspc_pkg::CFG_AW-1:0] i_cfg_addr;
    logic [wspc_pkg::CFG_DW-1:0] i_cfg_wdata;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [31:0]                 s_axis_tdata;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [31:0]                 m_axis_tdata;
    logic                        m_axis_tuser;

    int pending_cmds;
    int fail_count;
    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int long_hold_cycles = 0;
    int hold_left        = 0;
    bit hold_started     = 1'b0;
    int sent_ticks       = 0;

    wheel_speed_pi_controller_top #(
        .MAX_AVG_LENGTH(64),
        .WARMUP_TICKS  (100)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    duty_cmd_checker #(
        .MAX_WINDOW  (64),
        .WARMUP_TICKS(100)
    ) u_cmd_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tick_valid(s_axis_tvalid),
        .i_tick_ready(s_axis_tready),
        .i_tick_data (s_axis_tdata),
        .i_cmd_valid (m_axis_tvalid),
        .i_cmd_ready (m_axis_tready),
        .i_cmd_data  (m_axis_tdata),
        .i_cmd_warm  (m_axis_tuser),
        .o_pending   (pending_cmds),
        .o_fail_count(fail_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_cycles != 0 && !hold_started) begin
                hold_started = 1'b1;
                hold_left    = long_hold_cycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_tick(input logic [9:0] edges, input logic [15:0] target);
        if ($urandom_range(99) < send_idle_pct) begin
            repeat ($urandom_range(1, 70)) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, target, edges};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain(input int settle);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_cmds != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [wspc_pkg::CFG_AW-1:0] addr,
                             input logic [15:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [15:0] scale, input logic [15:0] len,
                                input logic [15:0] kp, input logic [15:0] ki,
                                input logic [15:0] dmax, input logic [15:0] dmin);
        drain(16);
        write_reg(wspc_pkg::REG_SPEED_SCALE, scale);
        write_reg(wspc_pkg::REG_AVG_LENGTH, len);
        write_reg(wspc_pkg::REG_PROP_GAIN, kp);
        write_reg(wspc_pkg::REG_INTEG_GAIN, ki);
        write_reg(wspc_pkg::REG_DUTY_MAX, dmax);
        write_reg(wspc_pkg::REG_DUTY_MIN, dmin);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] random_gain();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom());
            default: return 16'($urandom_range(0, 600));
        endcase
    endfunction

    function automatic t_loop_cfg random_setting();
        t_loop_cfg c;
        case ($urandom_range(7))
            0: c.scale = 16'hFFFF;
            1: c.scale = 16'd0;
            2: c.scale = 16'($urandom_range(1, 8));
            3: c.scale = 16'($urandom());
            default: c.scale = 16'($urandom_range(16, 1024));
        endcase
        case ($urandom_range(6))
            0: c.len = 16'd0;
            1: c.len = 16'd1;
            2: c.len = 16'd64;
            3: c.len = 16'($urandom_range(65, 127));
            4: c.len = 16'($urandom());
            default: c.len = 16'($urandom_range(2, 32));
        endcase
        c.kp = random_gain();
        c.ki = random_gain();
        case ($urandom_range(4))
            0: begin
                c.dmax = 16'hFFFF;
                c.dmin = 16'd0;
            end
            1: begin
                c.dmax = 16'd0;
                c.dmin = 16'hFFFF;
            end
            2: begin
                c.dmax = 16'($urandom());
                c.dmin = 16'($urandom());
            end
            default: begin
                c.dmax = 16'($urandom_range(30000, 65535));
                c.dmin = 16'($urandom_range(0, 20000));
            end
        endcase
        return c;
    endfunction

    task automatic send_random_tick(input logic [15:0] scale);
        logic [9:0]  edges;
        logic [15:0] target;
        int          near;
        case ($urandom_range(9))
            0: edges = 10'd0;
            1: edges = 10'd1023;
            2: edges = 10'($urandom_range(1, 15));
            default: edges = 10'($urandom_range(1, 1023));
        endcase
        near = int'(edges) * int'(scale) + int'($urandom_range(512)) - 256;
        case ($urandom_range(7))
            0: target = 16'd0;
            1: target = 16'hFFFF;
            2, 3: target = 16'($urandom());
            default: target = (near < 0) ? 16'd0 : ((near > 65535) ? 16'hFFFF : 16'(near));
        endcase
        sent_ticks++;
        send_tick(edges, target);
    endtask

    initial begin
        t_loop_cfg setting;
        int        phase_len;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset values: idle tick, speed saturation, fill
        send_tick(10'd0, 16'd1234);
        send_tick(10'd1023, 16'd0);
        send_tick(10'd1, 16'hFFFF);
        send_tick(10'd300, 16'h1234);

        // window shrunk onto the fill point: mean saturates; crossed clamps
        program_regs(16'hFFFF, 16'd3, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        send_tick(10'd1023, 16'd0);
        send_tick(10'd1, 16'hFFFF);
        send_tick(10'd0, 16'd7);

        // zero length taken as one, zero gains
        program_regs(16'd1, 16'd0, 16'd0, 16'd0, 16'd40000, 16'd100);
        send_tick(10'd1, 16'd0);
        send_tick(10'd1023, 16'hFFFF);
        send_tick(10'd512, 16'h5555);

        // zero scale: every tick dropped; oversize length capped
        program_regs(16'd0, 16'd127, 16'd256, 16'd26, 16'hFFFF, 16'd0);
        send_tick(10'd1023, 16'd1);
        send_tick(10'd1, 16'hFFFF);

        // length grown after the fill point, upper write bits dropped
        program_regs(16'd256, 16'hFF88, 16'h8000, 16'd1, 16'hFFFF, 16'd0);
        send_tick(10'd1023, 16'hFFFF);
        send_tick(10'd0, 16'd0);
        send_tick(10'd2, 16'hAAAA);

        while (sent_ticks < 1500) begin
            if (sent_ticks < 500) begin
                send_idle_pct = 9;
                recv_idle_pct = 71;
            end else if (sent_ticks < 1000) begin
                send_idle_pct = 71;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            setting = random_setting();
            // keep ticks active while the output is held off
            if (sent_ticks >= 1100 && long_hold_cycles == 0 && setting.scale == 16'd0)
                setting.scale = 16'd256;
            program_regs(setting.scale, setting.len, setting.kp, setting.ki,
                         setting.dmax, setting.dmin);
            if (sent_ticks >= 1100 && long_hold_cycles == 0) long_hold_cycles = 400;
            phase_len = $urandom_range(20, 120);
            repeat (phase_len) send_random_tick(setting.scale);
        end

        drain(100);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: wheel_speed_pi_controller_top.f
src/wspc_pkg.sv
src/wspc_div.sv
src/wspc_datapath.sv
src/wspc_ctrl.sv
src/wheel_speed_pi_controller_top.sv
src/wspc_checker.sv
verif/duty_cmd_checker.sv
verif/testbench.sv
